// File: rtl/core/sepq_pkg.sv
`timescale 1ns / 1ps

package sepq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int TAG_BITS    = 16;
    localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = 5;

    localparam logic [CNT_BITS-1:0] COUNT_FULL = CNT_BITS'(QUEUE_DEPTH);

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] time_val;
        logic [TAG_BITS-1:0]  tag;
    } entry_t;

    // One write port and one read port of the slot memory.
    typedef struct packed {
        logic                we;
        logic [IDX_BITS-1:0] waddr;
        entry_t              wdata;
        logic [IDX_BITS-1:0] raddr;
    } mem_req_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] out_time;
        logic [TAG_BITS-1:0]  out_tag;
        logic                 removed;
        status_t              status;
        logic [CNT_BITS-1:0]  entry_count;
    } result_t;

endpackage

// File: rtl/core/sepq_slots.sv
`timescale 1ns / 1ps

module sepq_slots (
    input  logic              aclk,
    input  sepq_pkg::mem_req_t req,
    output sepq_pkg::entry_t  rd_data
);

    sepq_pkg::entry_t mem [sepq_pkg::QUEUE_DEPTH];
    sepq_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
        rd_data_reg <= mem[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/sepq_seq.sv
`timescale 1ns / 1ps

module sepq_seq (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  sepq_pkg::func_t      in_func,
    input  sepq_pkg::entry_t     in_entry,
    output logic                 res_valid,
    input  logic                 res_ready,
    output sepq_pkg::result_t    res,
    output sepq_pkg::mem_req_t   mem_req,
    input  sepq_pkg::entry_t     mem_rd_data
);

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_INS_RD  = 7'b0000010,
        ST_INS_CMP = 7'b0000100,
        ST_INS_PUT = 7'b0001000,
        ST_RM_RD   = 7'b0010000,
        ST_RM_TAKE = 7'b0100000,
        ST_DONE    = 7'b1000000
    } state_t;

    state_t                           state_reg, state_next;
    logic [sepq_pkg::IDX_BITS-1:0]    head_reg, head_next;
    logic [sepq_pkg::CNT_BITS-1:0]    occ_reg, occ_next;
    logic [sepq_pkg::IDX_BITS-1:0]    idx_reg, idx_next;
    sepq_pkg::entry_t                 ent_reg, ent_next;
    logic [sepq_pkg::TIME_BITS-1:0]   rtime_reg, rtime_next;
    logic [sepq_pkg::TAG_BITS-1:0]    rtag_reg, rtag_next;
    logic                             removed_reg, removed_next;
    sepq_pkg::status_t                status_reg, status_next;

    logic [sepq_pkg::CNT_BITS-1:0]    occ_dec;
    logic [sepq_pkg::IDX_BITS-1:0]    idx_inc;
    logic [sepq_pkg::IDX_BITS-1:0]    phys_idx;
    logic [sepq_pkg::IDX_BITS-1:0]    phys_inc;
    logic                             new_earlier;

    assign occ_dec  = occ_reg - sepq_pkg::CNT_BITS'(1);
    assign idx_inc  = idx_reg + sepq_pkg::IDX_BITS'(1);
    // Slots form a ring starting at the head, so a removal never moves data.
    assign phys_idx = head_reg + idx_reg;
    assign phys_inc = head_reg + idx_inc;

    // The one comparator, reused on every step of the insertion scan.
    assign new_earlier = ent_reg.time_val < mem_rd_data.time_val;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        occ_next     = occ_reg;
        idx_next     = idx_reg;
        ent_next     = ent_reg;
        rtime_next   = rtime_reg;
        rtag_next    = rtag_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        mem_req      = '0;
        mem_req.raddr = phys_idx;

        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    ent_next     = in_entry;
                    rtime_next   = '0;
                    rtag_next    = '0;
                    removed_next = 1'b0;
                    status_next  = sepq_pkg::STATUS_OK;
                    if (in_func == sepq_pkg::FUNC_REMOVE) begin
                        if (occ_reg == '0) begin
                            status_next = sepq_pkg::STATUS_EMPTY;
                            state_next  = ST_DONE;
                        end else begin
                            idx_next   = '0;
                            state_next = ST_RM_RD;
                        end
                    end else begin
                        if (occ_reg == sepq_pkg::COUNT_FULL) begin
                            status_next = sepq_pkg::STATUS_FULL;
                            state_next  = ST_DONE;
                        end else if (occ_reg == '0) begin
                            idx_next   = '0;
                            state_next = ST_INS_PUT;
                        end else begin
                            idx_next   = occ_dec[sepq_pkg::IDX_BITS-1:0];
                            state_next = ST_INS_RD;
                        end
                    end
                end
            end
            ST_INS_RD: begin
                state_next = ST_INS_CMP;
            end
            ST_INS_CMP: begin
                // Only a strictly later stored time moves back, so ties stay in arrival order.
                if (new_earlier) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = phys_inc;
                    mem_req.wdata = mem_rd_data;
                    if (idx_reg == '0) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        idx_next   = idx_reg - sepq_pkg::IDX_BITS'(1);
                        state_next = ST_INS_RD;
                    end
                end else begin
                    idx_next   = idx_inc;
                    state_next = ST_INS_PUT;
                end
            end
            ST_INS_PUT: begin
                mem_req.we    = 1'b1;
                mem_req.waddr = phys_idx;
                mem_req.wdata = ent_reg;
                occ_next      = occ_reg + sepq_pkg::CNT_BITS'(1);
                state_next    = ST_DONE;
            end
            ST_RM_RD: begin
                state_next = ST_RM_TAKE;
            end
            ST_RM_TAKE: begin
                rtime_next   = mem_rd_data.time_val;
                rtag_next    = mem_rd_data.tag;
                removed_next = 1'b1;
                head_next    = head_reg + sepq_pkg::IDX_BITS'(1);
                occ_next     = occ_dec;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            occ_reg   <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        ent_reg     <= ent_next;
        rtime_reg   <= rtime_next;
        rtag_reg    <= rtag_next;
        removed_reg <= removed_next;
        status_reg  <= status_next;
    end

    // No transfer is taken while reset is held.
    assign in_ready  = aresetn && (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    always_comb begin
        res.out_time    = rtime_reg;
        res.out_tag     = rtag_reg;
        res.removed     = removed_reg;
        res.status      = status_reg;
        res.entry_count = occ_reg;
    end

endmodule

// File: rtl/core/stable_event_priority_queue_core.sv
`timescale 1ns / 1ps

// Time-ordered event queue holding up to 16 events, kept sorted by time with
// ties leaving in arrival order. Each input transfer on the s_axis channel is
// either an insert (tuser = 0, tdata carries time and tag) or a remove of the
// earliest event (tuser = 1). Every input transfer yields exactly one result
// transfer on m_axis carrying the removed event (if any), a status code and
// the entry count after the operation.
// An input is taken only while the sequencer is idle. An error goes straight
// to the result and a remove reads the head slot and takes its event. An
// insert into an empty queue writes the new event at once; otherwise the
// insert scan starts at the tail, reads one slot, compares it on the single
// time comparator and, while the stored time is later, moves it back one
// place through the one-read one-write slot memory, then writes the new
// event into the gap. Removal only advances a head pointer. With a ready
// receiver the sequencer is idle again when m_axis_tvalid rises.
// The sequencer may start the next item while a result waits in the output
// register; it holds its own result until that register is free, so a
// stalled receiver eventually stops input acceptance without losing data.
// Reset (aresetn low, synchronous) empties the queue and drops any pending
// result; slot contents are not cleared.
module stable_event_priority_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] event_time, [47:32] event_tag
    input  logic [47:0] s_axis_tdata,
    // [0] func
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] out_time, [47:32] out_tag, [52:48] entry_count, [55:53] zero
    output logic [55:0] m_axis_tdata,
    // [0] removed, [2:1] status
    output logic [2:0]  m_axis_tuser
);

    sepq_pkg::entry_t   in_entry;
    sepq_pkg::func_t    in_func;
    sepq_pkg::result_t  res;
    sepq_pkg::result_t  out_reg;
    sepq_pkg::mem_req_t mem_req;
    sepq_pkg::entry_t   mem_rd_data;
    logic               res_valid;
    logic               res_ready;
    logic               m_valid_reg;

    assign in_entry.time_val = s_axis_tdata[31:0];
    assign in_entry.tag      = s_axis_tdata[47:32];
    assign in_func           = sepq_pkg::func_t'(s_axis_tuser[0]);

    sepq_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (in_func),
        .in_entry    (in_entry),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    sepq_slots u_slots (
        .aclk    (aclk),
        .req     (mem_req),
        .rd_data (mem_rd_data)
    );

    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {3'b000, out_reg.entry_count, out_reg.out_tag, out_reg.out_time};
    assign m_axis_tuser  = {out_reg.status, out_reg.removed};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sepq_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int QUIET_FROM   = 1650;
    localparam int LONG_HOLD_AT = 500;

    // Keeps its own sorted copy of the queue and the results it must produce.
    class event_queue_scoreboard;
        entry_t  event_list[$];
        result_t pending_results[$];
        int      errors = 0;

        task report(string field, logic [63:0] got, logic [63:0] want);
            $display("ERROR %s: got 0x%0h, expected 0x%0h at %0t", field, got, want, $time);
            errors++;
        endtask

        function void note_request(func_t op, logic [TIME_BITS-1:0] ev_time,
                                   logic [TAG_BITS-1:0] ev_tag);
            result_t r;
            entry_t  e;
            int      pos;
            r = '0;
            r.status = STATUS_OK;
            if (op == FUNC_REMOVE) begin
                if (event_list.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    e = event_list.pop_front();
                    r.out_time = e.time_val;
                    r.out_tag  = e.tag;
                    r.removed  = 1'b1;
                end
            end else if (event_list.size() >= QUEUE_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                // Walk past every entry that is not later, so ties keep arrival order.
                pos = 0;
                while (pos < event_list.size() && ev_time >= event_list[pos].time_val)
                    pos++;
                e.time_val = ev_time;
                e.tag      = ev_tag;
                event_list.insert(pos, e);
            end
            r.entry_count = CNT_BITS'(event_list.size());
            pending_results.push_back(r);
        endfunction

        task check_response(logic [55:0] data, logic [2:0] user);
            result_t want;
            if (pending_results.size() == 0) begin
                report("result with nothing outstanding", {user, data}, 0);
                return;
            end
            want = pending_results.pop_front();
            if (data[31:0] !== want.out_time)
                report("out_time", data[31:0], want.out_time);
            if (data[47:32] !== want.out_tag)
                report("out_tag", data[47:32], want.out_tag);
            if (data[52:48] !== want.entry_count)
                report("entry_count", data[52:48], want.entry_count);
            if (data[55:53] !== 3'b000)
                report("tdata padding", data[55:53], 0);
            if (user[0] !== want.removed)
                report("removed", user[0], want.removed);
            if (user[2:1] !== want.status)
                report("status", user[2:1], want.status);
        endtask
    endclass

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic [0:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    logic idle_on      = 1'b1;
    logic hold_request = 1'b0;

    event_queue_scoreboard sb = new;

    stable_event_priority_queue_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #4 aclk = ~aclk;

    // Offers one item and returns at the edge where it is transferred.
    task automatic send_item(func_t op, logic [TIME_BITS-1:0] ev_time,
                             logic [TAG_BITS-1:0] ev_tag);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev_tag, ev_time};
        s_axis_tuser  <= op;
        do @(posedge aclk); while (s_axis_tready !== 1'b1);
        sb.note_request(op, ev_time, ev_tag);
    endtask

    // Mostly narrow times so that ties are common, plus the extremes and full-range values.
    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: pick_time = TIME_BITS'($urandom_range(0, 15));
            4:          pick_time = '0;
            5:          pick_time = '1;
            6:          pick_time = 32'hFFFF_FFF0 + TIME_BITS'($urandom_range(0, 15));
            default:    pick_time = $urandom;
        endcase
    endfunction

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready)
                sb.check_response(m_axis_tdata, m_axis_tuser);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (aresetn && idle_on && $urandom_range(0, 7) == 0) begin
                hold_left = $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int    sent;
        int    seg_len;
        int    insert_pct;
        int    k;
        int    wait_cycles;
        func_t op;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Removal from an empty queue, then a fill with extremes and equal times.
        send_item(FUNC_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_INSERT, 32'd5, 16'h0001);
        send_item(FUNC_INSERT, 32'd5, 16'h0002);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
        send_item(FUNC_INSERT, 32'd0, 16'h0000);
        send_item(FUNC_INSERT, 32'd5, 16'h0003);
        send_item(FUNC_INSERT, 32'hFFFF_FFFF, 16'h1234);
        send_item(FUNC_INSERT, 32'd0, 16'hFFFF);
        send_item(FUNC_INSERT, 32'h8000_0000, 16'h8000);
        send_item(FUNC_INSERT, 32'h7FFF_FFFF, 16'h7FFF);
        send_item(FUNC_INSERT, 32'd5, 16'h0004);
        send_item(FUNC_INSERT, 32'd1, 16'h0005);
        send_item(FUNC_INSERT, 32'hAAAA_AAAA, 16'h5555);
        send_item(FUNC_INSERT, 32'h5555_5555, 16'hAAAA);
        send_item(FUNC_INSERT, 32'd5, 16'h0006);
        send_item(FUNC_INSERT, 32'd2, 16'h0007);
        send_item(FUNC_INSERT, 32'd3, 16'h0008);
        // The queue is full now, so this event is dropped.
        send_item(FUNC_INSERT, 32'd4, 16'h0009);
        for (k = 0; k < 7; k++)
            send_item(FUNC_REMOVE, 32'h0000_0000, 16'h0000);

        // Segments lean toward filling, draining or balance so both full and empty recur.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            seg_len = $urandom_range(30, 120);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 50;
                default: insert_pct = 15;
            endcase
            for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
                if (sent == LONG_HOLD_AT)
                    hold_request = 1'b1;
                if (sent == QUIET_FROM)
                    idle_on = 1'b0;
                if ($urandom_range(0, 99) < insert_pct)
                    op = FUNC_INSERT;
                else
                    op = FUNC_REMOVE;
                send_item(op, pick_time(), TAG_BITS'($urandom));
                sent++;
            end
        end
        s_axis_tvalid <= 1'b0;

        wait_cycles = 0;
        while (sb.pending_results.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        if (sb.pending_results.size() != 0)
            sb.report("results never delivered", sb.pending_results.size(), 0);
        repeat (60) @(posedge aclk);

        if (sb.errors == 0) begin
            $display("** stable_event_priority_queue_core: PASSED **");
        end else begin
            $display("** stable_event_priority_queue_core: FAILED **");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout waiting for the queue to finish");
        $display("** stable_event_priority_queue_core: FAILED **");
        $finish;
    end

endmodule
